[src/lcdn_pkg.sv]
// shared types, codes and helper functions for the character lcd nibble interface
`default_nettype none
package lcdn_pkg;

  localparam int WAIT_BITS = 20;
  localparam int CFG_BITS  = 20;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_INIT  = 3'd1,
    OP_INSTR = 3'd2,
    OP_DATA  = 3'd3,
    OP_GOTO  = 3'd4,
    OP_CLEAR = 3'd5,
    OP_HEXU  = 3'd6,
    OP_HEXS  = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    REG_ENABLE_PULSE = 3'd0,
    REG_POWER_UP     = 3'd1,
    REG_FIRST_INIT   = 3'd2,
    REG_SHORT_INIT   = 3'd3,
    REG_BYTE_WAIT    = 3'd4,
    REG_CLEAR_WAIT   = 3'd5,
    REG_INIT_END     = 3'd6,
    REG_UNUSED       = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_PWR_WAIT   = 3'd1,
    PH_INIT_PULSE = 3'd2,
    PH_INIT_WAIT  = 3'd3,
    PH_NIB_PULSE  = 3'd4,
    PH_NIB_GAP    = 3'd5,
    PH_BYTE_WAIT  = 3'd6,
    PH_EXTRA_WAIT = 3'd7
  } phase_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] operand;
  } item_t;

  typedef struct packed {
    logic       lcd_enable;
    logic       lcd_register_select;
    logic [3:0] lcd_nibble;
    logic       busy_res;
    logic       accepted;
  } result_t;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_HEX_A = 8'h37;
  localparam logic [7:0] BYTE_CLEAR = 8'h01;
  localparam logic [7:0] GOTO_BIT   = 8'h80;

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h28;
      2'd1: b = 8'h06;
      2'd2: b = 8'h0f;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] digit_char(input logic [15:0] v, input logic [1:0] idx);
    logic [3:0] d;
    unique case (idx)
      2'd0: d = v[3:0];
      2'd1: d = v[7:4];
      2'd2: d = v[11:8];
      default: d = v[15:12];
    endcase
    return (d > 4'd9) ? CHAR_HEX_A + {4'd0, d} : CHAR_ZERO + {4'd0, d};
  endfunction

  function automatic logic [WAIT_BITS-1:0] clip_ticks(input logic [CFG_BITS-1:0] v);
    logic [WAIT_BITS-1:0] r;
    if (v == '0) begin
      r = WAIT_BITS'(1);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/lcdn_front.sv]
// front end: takes ticks and holds them in a two-entry queue for the sequencer
`default_nettype none
module lcdn_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [2:0]     opcode,
  input  wire logic [15:0]    operand,
  output logic                q_valid,
  input  wire logic           q_pop,
  output lcdn_pkg::item_t     q_item
);
  import lcdn_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid & in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{opcode: opcode_t'(opcode), operand: operand};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/lcdn_back.sv]
// back end: pin sequencer that runs commands tick by tick and registers results
`default_nettype none
module lcdn_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_write,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [19:0]    cfg_data,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire lcdn_pkg::item_t q_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lcdn_pkg::result_t   result
);
  import lcdn_pkg::*;

  logic [7:0]          enable_pulse;
  logic [CFG_BITS-1:0] power_up, first_init, short_init, byte_wait, clear_wait, init_end;

  phase_t               phase, phase_next;
  logic [WAIT_BITS-1:0] wait_counter, wait_counter_next;
  logic [7:0]           current_byte, current_byte_next;
  logic                 low_nibble_next, low_nibble_next_next;
  logic [3:0]           init_step, init_step_next;
  logic [15:0]          hex_value, hex_value_next;
  logic [1:0]           digit_index, digit_index_next;
  logic                 minus_pending, minus_pending_next;
  logic                 pin_e, pin_e_next, pin_rs, pin_rs_next;
  logic [3:0]           pin_nib, pin_nib_next;
  opcode_t              job, job_next;
  logic                 acc;

  logic                 sb;
  logic                 sb_digit;
  logic [7:0]           sb_byte;
  logic                 sb_rs;
  logic [7:0]           sb_final;
  logic [WAIT_BITS-1:0] wc_dec;
  logic [3:0]           step_inc;
  logic [15:0]          neg_val;

  assign q_pop = q_valid & (~out_valid | out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_pulse <= 8'd1;
      power_up     <= CFG_BITS'(40000);
      first_init   <= CFG_BITS'(4100);
      short_init   <= CFG_BITS'(100);
      byte_wait    <= CFG_BITS'(40);
      clear_wait   <= CFG_BITS'(3000);
      init_end     <= CFG_BITS'(2000);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE_PULSE: enable_pulse <= cfg_data[7:0];
        REG_POWER_UP:     power_up     <= cfg_data;
        REG_FIRST_INIT:   first_init   <= cfg_data;
        REG_SHORT_INIT:   short_init   <= cfg_data;
        REG_BYTE_WAIT:    byte_wait    <= cfg_data;
        REG_CLEAR_WAIT:   clear_wait   <= cfg_data;
        REG_INIT_END:     init_end     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wc_dec   = (wait_counter != '0) ? wait_counter - WAIT_BITS'(1) : '0;
  assign step_inc = init_step + 4'd1;
  assign neg_val  = 16'd0 - q_item.operand;

  always_comb begin
    phase_next           = phase;
    wait_counter_next    = wait_counter;
    current_byte_next    = current_byte;
    low_nibble_next_next = low_nibble_next;
    init_step_next       = init_step;
    hex_value_next       = hex_value;
    digit_index_next     = digit_index;
    minus_pending_next   = minus_pending;
    pin_e_next           = pin_e;
    pin_rs_next          = pin_rs;
    pin_nib_next         = pin_nib;
    job_next             = job;
    acc                  = 1'b0;
    sb                   = 1'b0;
    sb_digit             = 1'b0;
    sb_byte              = 8'd0;
    sb_rs                = 1'b0;
    sb_final             = 8'd0;

    if (phase == PH_IDLE) begin
      if (q_item.opcode != OP_NONE) begin
        acc      = 1'b1;
        job_next = q_item.opcode;
        unique case (q_item.opcode)
          OP_INIT: begin
            pin_e_next        = 1'b0;
            pin_rs_next       = 1'b0;
            phase_next        = PH_PWR_WAIT;
            wait_counter_next = clip_ticks(power_up);
          end
          OP_INSTR: begin
            sb = 1'b1; sb_byte = q_item.operand[7:0];
          end
          OP_DATA: begin
            sb = 1'b1; sb_byte = q_item.operand[7:0]; sb_rs = 1'b1;
          end
          OP_GOTO: begin
            sb = 1'b1; sb_byte = q_item.operand[7:0] | GOTO_BIT;
          end
          OP_CLEAR: begin
            sb = 1'b1; sb_byte = BYTE_CLEAR;
          end
          default: begin
            minus_pending_next = 1'b0;
            hex_value_next     = q_item.operand;
            if (q_item.opcode == OP_HEXS && q_item.operand[15]) begin
              minus_pending_next = 1'b1;
              hex_value_next     = neg_val;
            end
            if (hex_value_next[15:12] != 4'd0) digit_index_next = 2'd3;
            else if (hex_value_next[11:8] != 4'd0) digit_index_next = 2'd2;
            else if (hex_value_next[7:4] != 4'd0) digit_index_next = 2'd1;
            else digit_index_next = 2'd0;
            sb       = 1'b1;
            sb_rs    = 1'b1;
            sb_digit = ~minus_pending_next;
            sb_byte  = CHAR_MINUS;
          end
        endcase
      end
    end else begin
      wait_counter_next = wc_dec;
      if (wc_dec == '0) begin
        unique case (phase)
          PH_PWR_WAIT: begin
            init_step_next    = 4'd0;
            pin_e_next        = 1'b1;
            pin_rs_next       = 1'b0;
            pin_nib_next      = 4'd3;
            phase_next        = PH_INIT_PULSE;
            wait_counter_next = clip_ticks({12'd0, enable_pulse});
          end
          PH_INIT_PULSE: begin
            pin_e_next        = 1'b0;
            pin_rs_next       = 1'b0;
            phase_next        = PH_INIT_WAIT;
            wait_counter_next = clip_ticks((init_step == 4'd0) ? first_init : short_init);
          end
          PH_INIT_WAIT: begin
            init_step_next = step_inc;
            if (step_inc < 4'd4) begin
              pin_e_next        = 1'b1;
              pin_rs_next       = 1'b0;
              pin_nib_next      = (step_inc < 4'd3) ? 4'd3 : 4'd2;
              phase_next        = PH_INIT_PULSE;
              wait_counter_next = clip_ticks({12'd0, enable_pulse});
            end else begin
              sb = 1'b1; sb_byte = init_byte(2'd0);
            end
          end
          PH_NIB_PULSE: begin
            pin_e_next = 1'b0;
            if (!low_nibble_next) begin
              phase_next        = PH_NIB_GAP;
              wait_counter_next = WAIT_BITS'(1);
            end else begin
              phase_next        = PH_BYTE_WAIT;
              wait_counter_next = clip_ticks(byte_wait);
            end
          end
          PH_NIB_GAP: begin
            low_nibble_next_next = 1'b1;
            pin_e_next           = 1'b1;
            pin_nib_next         = current_byte[3:0];
            phase_next           = PH_NIB_PULSE;
            wait_counter_next    = clip_ticks({12'd0, enable_pulse});
          end
          PH_BYTE_WAIT: begin
            priority case (job)
              OP_INIT: begin
                init_step_next = step_inc;
                if (step_inc >= 4'd4 && step_inc < 4'd8) begin
                  sb = 1'b1; sb_byte = init_byte(step_inc[1:0]);
                end else begin
                  phase_next        = PH_EXTRA_WAIT;
                  wait_counter_next = clip_ticks(init_end);
                end
              end
              OP_CLEAR: begin
                phase_next        = PH_EXTRA_WAIT;
                wait_counter_next = clip_ticks(clear_wait);
              end
              OP_HEXU, OP_HEXS: begin
                if (minus_pending) begin
                  minus_pending_next = 1'b0;
                  sb = 1'b1; sb_rs = 1'b1; sb_digit = 1'b1;
                end else if (digit_index == 2'd0) begin
                  pin_e_next        = 1'b0;
                  phase_next        = PH_IDLE;
                  wait_counter_next = '0;
                end else begin
                  digit_index_next = digit_index - 2'd1;
                  sb = 1'b1; sb_rs = 1'b1; sb_digit = 1'b1;
                end
              end
              default: begin
                pin_e_next        = 1'b0;
                phase_next        = PH_IDLE;
                wait_counter_next = '0;
              end
            endcase
          end
          default: begin
            pin_e_next        = 1'b0;
            phase_next        = PH_IDLE;
            wait_counter_next = '0;
          end
        endcase
      end
    end

    sb_final = sb_digit ? digit_char(hex_value_next, digit_index_next) : sb_byte;
    if (sb) begin
      current_byte_next    = sb_final;
      low_nibble_next_next = 1'b0;
      pin_e_next           = 1'b1;
      pin_rs_next          = sb_rs;
      pin_nib_next         = sb_final[7:4];
      phase_next           = PH_NIB_PULSE;
      wait_counter_next    = clip_ticks({12'd0, enable_pulse});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      wait_counter    <= '0;
      current_byte    <= 8'd0;
      low_nibble_next <= 1'b0;
      init_step       <= 4'd0;
      hex_value       <= 16'd0;
      digit_index     <= 2'd0;
      minus_pending   <= 1'b0;
      pin_e           <= 1'b0;
      pin_rs          <= 1'b0;
      pin_nib         <= 4'd0;
      job             <= OP_NONE;
      out_valid       <= 1'b0;
    end else begin
      if (q_pop) begin
        phase           <= phase_next;
        wait_counter    <= wait_counter_next;
        current_byte    <= current_byte_next;
        low_nibble_next <= low_nibble_next_next;
        init_step       <= init_step_next;
        hex_value       <= hex_value_next;
        digit_index     <= digit_index_next;
        minus_pending   <= minus_pending_next;
        pin_e           <= pin_e_next;
        pin_rs          <= pin_rs_next;
        pin_nib         <= pin_nib_next;
        job             <= job_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= '{lcd_enable: pin_e_next, lcd_register_select: pin_rs_next,
                  lcd_nibble: pin_nib_next, busy_res: (phase_next != PH_IDLE),
                  accepted: acc};
    end
  end

endmodule
`default_nettype wire

[src/char_lcd_nibble_interface.sv]
// top level of the character lcd nibble interface
// Each input item is one tick of the lcd timing and yields exactly one result item with
// the pin levels, busy and accepted flags. One item per clock is sustained while out_ready
// stays high: a two-entry queue feeds the sequencer, which steps once per item and writes
// a registered result, so each item passes through the queue and then the result register.
`default_nettype none
module char_lcd_nibble_interface (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [15:0] operand,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             lcd_enable,
  output logic             lcd_register_select,
  output logic [3:0]       lcd_nibble,
  output logic             busy_res,
  output logic             accepted
);
  import lcdn_pkg::*;

  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  result_t result;

  lcdn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .operand  (operand),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  lcdn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign lcd_enable          = result.lcd_enable;
  assign lcd_register_select = result.lcd_register_select;
  assign lcd_nibble          = result.lcd_nibble;
  assign busy_res            = result.busy_res;
  assign accepted            = result.accepted;

endmodule
`default_nettype wire
